[rtl/sws_pkg.sv]
// Shared types and constants of the sliding window statistics block.
`timescale 1ns / 1ps
package sws_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 11;
  localparam int SUM_W    = 27;
  localparam int SQS_W    = 41;
  localparam int DVD_W    = 68;
  localparam int DVS_W    = 22;
  localparam int STEP_W   = 7;
  localparam int REM_W    = 27;
  localparam int ROOT_W   = 24;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_CNTRST = 2'd2;

  localparam logic MODE_DIV  = 1'b0;
  localparam logic MODE_SQRT = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOT = 16'sh8000;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic signed [SAMPLE_W-1:0]  sample;
  } req_t;

  typedef struct packed {
    logic                start;
    logic                mode;
    logic [DVD_W-1:0]    dividend;
    logic [DVS_W-1:0]    divisor;
    logic [STEP_W-1:0]   steps;
  } arith_req_t;

  typedef struct packed {
    logic [10:0]          peak_count;
    logic [31:0]          total_evictions;
    logic [31:0]          total_writes;
    logic                 window_full;
    logic signed [15:0]   evicted_value;
    logic                 evicted_valid;
    logic signed [15:0]   maximum;
    logic signed [15:0]   minimum;
    logic [23:0]          stddev_q8;
    logic signed [23:0]   mean_q8;
    logic signed [25:0]   window_sum;
    logic [10:0]          sample_count;
  } res_t;

endpackage

[rtl/sws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[rtl/sws_front.sv]
// Front end: accepts requests into a two-entry queue for the back end.
`timescale 1ns / 1ps
module sws_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sws_pkg::req_t  in_req,
  output logic           q_valid,
  input  logic           q_pop,
  output sws_pkg::req_t  q_req
);
  import sws_pkg::*;

  req_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_req;
    end
  end
endmodule

[rtl/sws_arith.sv]
// Shared iterative unit: restoring divide, one bit a cycle, or square root, one root bit (two radicand bits) a cycle.
`timescale 1ns / 1ps
module sws_arith (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sws_pkg::arith_req_t           req,
  output logic                          busy,
  output logic                          done,
  output logic [sws_pkg::DVD_W-1:0]     quotient,
  output logic [sws_pkg::ROOT_W-1:0]    root
);
  import sws_pkg::*;

  logic               busy_r, done_r, mode_r;
  logic [STEP_W-1:0]  cnt_r;
  logic [DVD_W-1:0]   sh_r, sh_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0]   dvs_r;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [REM_W-1:0]   t, trial;

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    t        = '0;
    trial    = '0;
    if (mode_r == MODE_DIV) begin
      t     = {rem_r[REM_W-2:0], sh_r[DVD_W-1]};
      trial = {{(REM_W-DVS_W){1'b0}}, dvs_r};
      if (t >= trial) begin
        rem_nxt = t - trial;
        sh_nxt  = {sh_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = t;
        sh_nxt  = {sh_r[DVD_W-2:0], 1'b0};
      end
    end else begin
      t      = {rem_r[REM_W-3:0], sh_r[DVD_W-1:DVD_W-2]};
      trial  = {1'b0, root_r, 2'b01};
      sh_nxt = {sh_r[DVD_W-3:0], 2'b00};
      if (t >= trial) begin
        rem_nxt  = t - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = t;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      mode_r <= req.mode;
      sh_r   <= req.dividend;
      dvs_r  <= req.divisor;
      cnt_r  <= req.steps;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      sh_r   <= sh_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      cnt_r  <= cnt_r - STEP_W'(1);
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = sh_r;
  assign root     = root_r;
endmodule

[rtl/sws_back.sv]
// Back end: window state, sample ring, statistics sequencing and result register.
`timescale 1ns / 1ps
module sws_back #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [10:0]    cfg_wdata,
  input  logic           q_valid,
  output logic           q_pop,
  input  sws_pkg::req_t  q_req,
  output logic           res_valid,
  input  logic           res_ready,
  output sws_pkg::res_t  res
);
  import sws_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int WL_MAX = (MAX_WINDOW > 2047) ? 2047 : MAX_WINDOW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_UPD  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_MDIV = 4'd4;
  localparam logic [3:0] S_VSUB = 4'd5;
  localparam logic [3:0] S_VDIV = 4'd6;
  localparam logic [3:0] S_SQ   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]                state_r;
  req_t                      req_r;
  logic                      evict_r;
  logic [CNT_W-1:0]          wl_r;
  logic [AW-1:0]             wp_r;
  logic [CNT_W-1:0]          held_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [SQS_W-1:0]          sqs_r;
  logic signed [SAMPLE_W-1:0] lo_r, hi_r;
  logic [31:0]               wcnt_r, ecnt_r;
  logic [CNT_W-1:0]          peak_r;
  logic                      evv_r;
  logic signed [SAMPLE_W-1:0] evd_r;
  logic [51:0]               a_r, b_r;
  logic [DVS_W-1:0]          n2_r;
  logic signed [23:0]        mean_r;
  logic [23:0]               sd_r;
  logic                      res_valid_r;
  res_t                      res_r;

  logic [CNT_W-1:0]          wl_eff;
  logic signed [SAMPLE_W-1:0] ev_s;
  logic [31:0]               s_sq, ev_sq;
  logic [25:0]               mag;
  logic [51:0]               d;
  logic [33:0]               mq;
  logic [33:0]               mq_s;
  logic                      ram_re, ram_we;
  logic [SAMPLE_W-1:0]       ram_rd;
  arith_req_t                areq;
  logic                      abusy, adone;
  logic [DVD_W-1:0]          aq;
  logic [ROOT_W-1:0]         aroot;

  always_comb begin
    if (cfg_wdata == '0) begin
      wl_eff = CNT_W'(1);
    end else if (32'(cfg_wdata) > WL_MAX) begin
      wl_eff = CNT_W'(WL_MAX);
    end else begin
      wl_eff = cfg_wdata;
    end
  end

  assign ev_s  = signed'(ram_rd);
  assign s_sq  = 32'(req_r.sample * req_r.sample);
  assign ev_sq = 32'(ev_s * ev_s);
  assign mag   = sum_r[SUM_W-1] ? 26'(-sum_r) : 26'(sum_r);
  assign d     = (a_r >= b_r) ? a_r - b_r : '0;
  assign mq    = aq[33:0];
  assign mq_s  = sum_r[SUM_W-1] ? -mq : mq;

  assign q_pop  = (state_r == S_IDLE) && q_valid;
  assign ram_re = q_pop && (q_req.opcode == OP_WRITE) && (held_r >= wl_r);
  assign ram_we = (state_r == S_UPD) && (req_r.opcode == OP_WRITE);

  sws_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (req_r.sample),
    .re    (ram_re),
    .raddr (wp_r),
    .rdata (ram_rd)
  );

  always_comb begin
    areq       = '0;
    areq.mode  = MODE_DIV;
    if (state_r == S_MUL && held_r != '0) begin
      areq.start    = 1'b1;
      areq.dividend = {mag, 8'd0, 34'd0};
      areq.divisor  = DVS_W'(held_r);
      areq.steps    = STEP_W'(34);
    end else if (state_r == S_VSUB) begin
      areq.start    = 1'b1;
      areq.dividend = {d, 16'd0};
      areq.divisor  = n2_r;
      areq.steps    = STEP_W'(DVD_W);
    end else if (state_r == S_VDIV && adone) begin
      areq.start    = 1'b1;
      areq.mode     = MODE_SQRT;
      areq.dividend = {aq[47:0], 20'd0};
      areq.steps    = STEP_W'(ROOT_W);
    end
  end

  sws_arith u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (areq),
    .busy     (abusy),
    .done     (adone),
    .quotient (aq),
    .root     (aroot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wl_r        <= CNT_W'(WL_MAX);
      wp_r        <= '0;
      held_r      <= '0;
      sum_r       <= '0;
      sqs_r       <= '0;
      lo_r        <= SAMPLE_TOP;
      hi_r        <= SAMPLE_BOT;
      wcnt_r      <= '0;
      ecnt_r      <= '0;
      peak_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!res_valid_r || res_ready)) begin
        res_valid_r <= 1'b1;
      end else if (res_valid_r && res_ready) begin
        res_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        wl_r   <= wl_eff;
        wp_r   <= '0;
        held_r <= '0;
        sum_r  <= '0;
        sqs_r  <= '0;
        lo_r   <= SAMPLE_TOP;
        hi_r   <= SAMPLE_BOT;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            state_r <= ram_re ? S_READ : S_UPD;
          end
        end
        S_READ: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          state_r <= S_MUL;
          if (req_r.opcode == OP_WRITE) begin
            wp_r   <= (32'(wp_r) + 1 == 32'(wl_r)) ? '0 : wp_r + AW'(1);
            wcnt_r <= wcnt_r + 32'd1;
            if (evict_r) begin
              sum_r  <= sum_r - SUM_W'(ev_s) + SUM_W'(req_r.sample);
              sqs_r  <= sqs_r - SQS_W'(ev_sq) + SQS_W'(s_sq);
              ecnt_r <= ecnt_r + 32'd1;
              if (held_r > peak_r) begin
                peak_r <= held_r;
              end
            end else begin
              sum_r  <= sum_r + SUM_W'(req_r.sample);
              sqs_r  <= sqs_r + SQS_W'(s_sq);
              held_r <= held_r + CNT_W'(1);
              if (held_r + CNT_W'(1) > peak_r) begin
                peak_r <= held_r + CNT_W'(1);
              end
            end
            if (req_r.sample < lo_r) lo_r <= req_r.sample;
            if (req_r.sample > hi_r) hi_r <= req_r.sample;
          end else if (req_r.opcode == OP_CLEAR) begin
            wp_r   <= '0;
            held_r <= '0;
            sum_r  <= '0;
            sqs_r  <= '0;
            lo_r   <= SAMPLE_TOP;
            hi_r   <= SAMPLE_BOT;
          end else if (req_r.opcode == OP_CNTRST) begin
            wcnt_r <= '0;
            ecnt_r <= '0;
            peak_r <= '0;
          end
        end
        S_MUL: begin
          state_r <= (held_r == '0) ? S_OUT : S_MDIV;
        end
        S_MDIV: begin
          if (adone) begin
            state_r <= (held_r < CNT_W'(2)) ? S_OUT : S_VSUB;
          end
        end
        S_VSUB: begin
          state_r <= S_VDIV;
        end
        S_VDIV: begin
          if (adone) begin
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (adone) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid_r || res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r   <= q_req;
      evict_r <= ram_re;
    end
    if (state_r == S_UPD) begin
      evv_r <= evict_r && (req_r.opcode == OP_WRITE);
      evd_r <= (evict_r && (req_r.opcode == OP_WRITE)) ? ev_s : '0;
    end
    if (state_r == S_MUL) begin
      a_r    <= 52'(held_r) * 52'(sqs_r);
      b_r    <= 52'(mag) * 52'(mag);
      n2_r   <= DVS_W'(held_r) * DVS_W'(held_r);
      mean_r <= '0;
      sd_r   <= '0;
    end
    if (state_r == S_MDIV && adone) begin
      mean_r <= signed'(mq_s[23:0]);
    end
    if (state_r == S_SQ && adone) begin
      sd_r <= aroot;
    end
    if (state_r == S_OUT && (!res_valid_r || res_ready)) begin
      res_r.sample_count    <= held_r;
      res_r.window_sum      <= sum_r[25:0];
      res_r.mean_q8         <= mean_r;
      res_r.stddev_q8       <= sd_r;
      res_r.minimum         <= (held_r != '0) ? lo_r : '0;
      res_r.maximum         <= (held_r != '0) ? hi_r : '0;
      res_r.evicted_valid   <= evv_r;
      res_r.evicted_value   <= evd_r;
      res_r.window_full     <= (held_r == wl_r);
      res_r.total_writes    <= wcnt_r;
      res_r.total_evictions <= ecnt_r;
      res_r.peak_count      <= peak_r;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_held_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= wl_r) else $error("held count above window length");
  a_ptr_lt_len: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wp_r) < 32'(wl_r)) else $error("write pointer outside window");
  a_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !abusy) else $error("arith unit busy while idle");
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (held_r == wl_r)) else $error("eviction before window full");
endmodule

[rtl/sliding_window_stats.sv]
// Top level of the sliding window mean and variance block.
//
// Channel  Dir  Handshake          Payload
// in_      in   tvalid/tready      tuser: opcode; tdata: sample
// out_     out  tvalid/tready      tdata: count, sum, mean, stddev, min, max, evict, counters
// cfg_     in   we (no wait)       wdata: window_length
//
// The work for a request depends on the samples held after it (a write into a full window
// also reads the evicted sample). With one sample the shared divide/square-root unit runs
// a 34-step mean divide; once two samples are held it runs a 34-step mean divide, a
// 68-step variance divide and a 24-step root in turn, and with none it runs no divide.
// Reset is synchronous, active low; the sample ring needs no clearing pass.
// A two-entry request queue lets the input side accept up to two requests while the back end
// works or while a finished result waits on out_tready.
`timescale 1ns / 1ps
module sliding_window_stats #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // [15:0] sample
  input  logic [1:0]   in_tuser,   // [1:0] opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  // [10:0] sample_count, [36:11] window_sum, [60:37] mean_q8, [84:61] stddev_q8,
  // [100:85] minimum, [116:101] maximum, [117] evicted_valid, [133:118] evicted_value,
  // [134] window_full, [166:135] total_writes, [198:167] total_evictions,
  // [209:199] peak_count, [215:210] zero
  output logic [215:0] out_tdata,
  input  logic         cfg_we,
  input  logic [10:0]  cfg_wdata
);
  import sws_pkg::*;

  req_t in_req, q_req;
  logic q_valid, q_pop;
  logic res_valid;
  res_t res;

  // Pack the request: opcode rides on tuser, the sample on tdata.
  assign in_req.opcode = in_tuser;
  assign in_req.sample = signed'(in_tdata);

  sws_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_req    (q_req)
  );

  sws_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_req     (q_req),
    .res_valid (res_valid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Result fields packed from the lowest bit up; the struct already runs in that order.
  assign out_tvalid = res_valid;
  assign out_tdata  = {6'd0, res};
endmodule
